// ===== hdl/scic_pkg.sv =====
// Shared types and constants for the scanline interrupt and coprocessor bus control core
package scic_pkg;

	// Scanlines in one frame; line events at or past this are ignored
	localparam logic [9:0] LINES_PER_FRAME = 10'd262;

	// Configuration register indexes
	localparam logic [2:0] REG_LINE_RELOAD  = 3'd0;
	localparam logic [2:0] REG_LINE_IRQ_EN  = 3'd1;
	localparam logic [2:0] REG_FRAME_IRQ_EN = 3'd2;
	localparam logic [2:0] REG_INTERLACE    = 3'd3;
	localparam logic [2:0] REG_ACTIVE_END   = 3'd4;

	// Configuration reset values
	localparam logic [7:0] RST_LINE_RELOAD = 8'd255;
	localparam logic [8:0] RST_ACTIVE_END  = 9'd224;

	// Interrupt levels seen on acknowledge
	localparam logic [2:0] LEVEL_LINE  = 3'd4;
	localparam logic [2:0] LEVEL_FRAME = 3'd6;

	// Event kinds; the eighth code means nothing
	typedef enum logic [2:0] {
		ACT_FRAME_START  = 3'd0,
		ACT_LINE_END     = 3'd1,
		ACT_IRQ_ACK      = 3'd2,
		ACT_BUSREQ_WRITE = 3'd3,
		ACT_RESET_WRITE  = 3'd4,
		ACT_BANK_WRITE   = 3'd5,
		ACT_BUSACK_READ  = 3'd6
	} action_t;

	typedef struct packed {
		logic [7:0] line_reload;
		logic       line_irq_enable;
		logic       frame_irq_enable;
		logic       interlace_mode;
		logic [8:0] active_end_line;
	} cfg_t;

	typedef struct packed {
		logic [2:0] action;
		logic [8:0] line_number;
		logic [2:0] ack_level;
		logic       bit_value;
	} item_t;

	typedef struct packed {
		logic [23:0] bank_base;
		logic        bus_ack;
		logic        coproc_irq;
		logic        frame_pending;
		logic        line_pending;
		logic [7:0]  status_bits;
		logic        frame_irq;
		logic        line_irq;
	} res_t;

endpackage

// ===== hdl/scic_cfg.sv =====
// APB configuration registers of the scanline interrupt core
module scic_cfg import scic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// Write the addressed register on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_reload      <= RST_LINE_RELOAD;
			cfg_q.line_irq_enable  <= 1'b0;
			cfg_q.frame_irq_enable <= 1'b0;
			cfg_q.interlace_mode   <= 1'b0;
			cfg_q.active_end_line  <= RST_ACTIVE_END;
		end else if (wr_en) begin
			case (reg_idx)
				REG_LINE_RELOAD:  cfg_q.line_reload      <= pwdata[7:0];
				REG_LINE_IRQ_EN:  cfg_q.line_irq_enable  <= pwdata[0];
				REG_FRAME_IRQ_EN: cfg_q.frame_irq_enable <= pwdata[0];
				REG_INTERLACE:    cfg_q.interlace_mode   <= pwdata[0];
				REG_ACTIVE_END:   cfg_q.active_end_line  <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_LINE_RELOAD:  prdata = {24'd0, cfg_q.line_reload};
			REG_LINE_IRQ_EN:  prdata = {31'd0, cfg_q.line_irq_enable};
			REG_FRAME_IRQ_EN: prdata = {31'd0, cfg_q.frame_irq_enable};
			REG_INTERLACE:    prdata = {31'd0, cfg_q.interlace_mode};
			REG_ACTIVE_END:   prdata = {23'd0, cfg_q.active_end_line};
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== hdl/scic_event.sv =====
// Event decode, interrupt state and coprocessor control bits
module scic_event import scic_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  fire,
	input  item_t item,
	output res_t  res
);

	// Line counter is 8 bits wide, as wide as the reload value
	logic [7:0] cnt_q,   cnt_d;
	logic       vblank_q, vblank_d;
	logic       odd_q,   odd_d;
	logic       vint_q,  vint_d;
	logic       lpend_q, lpend_d;
	logic       fpend_q, fpend_d;
	logic       cirq_q,  cirq_d;
	logic       breq_q,  breq_d;
	logic       crst_q,  crst_d;
	// Bank bits 15 to 23, bit 15 lowest
	logic [8:0] bank_q,  bank_d;
	logic       raise4, raise6;
	logic       line_in_frame;

	assign line_in_frame = {1'b0, item.line_number} < LINES_PER_FRAME;

	// Work out the state after this event
	always_comb begin
		cnt_d    = cnt_q;
		vblank_d = vblank_q;
		odd_d    = odd_q;
		vint_d   = vint_q;
		lpend_d  = lpend_q;
		fpend_d  = fpend_q;
		cirq_d   = cirq_q;
		breq_d   = breq_q;
		crst_d   = crst_q;
		bank_d   = bank_q;
		raise4   = 1'b0;
		raise6   = 1'b0;
		case (item.action)
			ACT_FRAME_START: begin
				vblank_d = 1'b0;
				if (cfg.interlace_mode)
					odd_d = ~odd_q;
			end
			ACT_LINE_END: begin
				if (line_in_frame) begin
					cirq_d = 1'b0;
					if (item.line_number <= cfg.active_end_line) begin
						if (cnt_q == 8'd0) begin
							cnt_d   = cfg.line_reload;
							lpend_d = 1'b1;
							raise4  = cfg.line_irq_enable;
						end else begin
							cnt_d = cnt_q - 8'd1;
						end
					end else begin
						cnt_d = cfg.line_reload;
					end
					if (item.line_number == cfg.active_end_line) begin
						vblank_d = 1'b1;
						vint_d   = 1'b1;
						fpend_d  = 1'b1;
						raise6   = cfg.frame_irq_enable;
						if (crst_q && !breq_q)
							cirq_d = 1'b1;
					end
				end
			end
			ACT_IRQ_ACK: begin
				if (item.ack_level == LEVEL_LINE) begin
					lpend_d = 1'b0;
				end else if (item.ack_level == LEVEL_FRAME) begin
					vint_d  = 1'b0;
					fpend_d = 1'b0;
				end
			end
			ACT_BUSREQ_WRITE: breq_d = item.bit_value;
			ACT_RESET_WRITE:  crst_d = item.bit_value;
			ACT_BANK_WRITE:   bank_d = {item.bit_value, bank_q[8:1]};
			default: ;
		endcase
	end

	// Advance the state when the event leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			vblank_q <= 1'b0;
			odd_q    <= 1'b0;
			vint_q   <= 1'b0;
			lpend_q  <= 1'b0;
			fpend_q  <= 1'b0;
			cirq_q   <= 1'b0;
			breq_q   <= 1'b0;
			crst_q   <= 1'b0;
			bank_q   <= '0;
		end else if (fire) begin
			cnt_q    <= cnt_d;
			vblank_q <= vblank_d;
			odd_q    <= odd_d;
			vint_q   <= vint_d;
			lpend_q  <= lpend_d;
			fpend_q  <= fpend_d;
			cirq_q   <= cirq_d;
			breq_q   <= breq_d;
			crst_q   <= crst_d;
			bank_q   <= bank_d;
		end
	end

	// Report the state after the event
	always_comb begin
		res.line_irq      = raise4;
		res.frame_irq     = raise6;
		res.status_bits   = {vint_d, 2'b00, odd_d, vblank_d, 3'b000};
		res.line_pending  = lpend_d;
		res.frame_pending = fpend_d;
		res.coproc_irq    = cirq_d;
		res.bus_ack       = ~(breq_d & crst_d);
		res.bank_base     = {bank_d, 15'd0};
	end

endmodule

// ===== hdl/scic_out_reg.sv =====
// Result register on the master-side stream
module scic_out_reg import scic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  res_t        in_res,
	output logic        in_ready,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata
);

	logic valid_q;
	res_t res_q;

	assign in_ready = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, res_q};

	// Hold the result until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (in_ready)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			res_q <= in_res;
	end

endmodule

// ===== hdl/scanline_interrupt_and_z80_bus_control_core.sv =====
// Scanline interrupt timing and coprocessor bus control, top level
// Path: a result passes the input register, then the result register.
// Throughput: one beat per cycle while m_tready does not stall the output; the event logic
// between the two registers is a single pass of decrement, compares and flag updates.
// Reset: arst_n asynchronously clears the valid flags and event state and loads register defaults.
module scanline_interrupt_and_z80_bus_control_core import scic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Event stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [8:0] line_number, [11:9] ack_level, [12] bit_value
	input  logic [2:0]  s_tuser,  // [2:0] action
	// Result stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] line_irq, [1] frame_irq, [9:2] status_bits, [10] line_pending,
	// [11] frame_pending, [12] coproc_irq, [13] bus_ack, [37:14] bank_base
	output logic [39:0] m_tdata
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	logic  adv_s1;
	logic  fire_s1;
	res_t  res_s1;

	scic_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register
	assign s_tready = !valid_s1 || adv_s1;
	assign fire_s1  = valid_s1 && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.action      <= s_tuser;
			item_s1.line_number <= s_tdata[8:0];
			item_s1.ack_level   <= s_tdata[11:9];
			item_s1.bit_value   <= s_tdata[12];
		end
	end

	scic_event u_event (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire_s1),
		.item   (item_s1),
		.res    (res_s1)
	);

	scic_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_res   (res_s1),
		.in_ready (adv_s1),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// A raised line interrupt always leaves its pending flag set
	a_line_irq_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[10])
		else $error("line interrupt raised without pending flag");

	// A raised frame interrupt sets the vertical flag and its pending flag
	a_frame_irq_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[9] && m_tdata[11])
		else $error("frame interrupt raised without status or pending flag");

	// An event held in the input stage stays there while the output stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost an event under stall");

	// Bank base only ever carries bits 15 to 23
	a_bank_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[28:14] == 15'd0)
		else $error("bank base low bits set");

endmodule
